// File: rtl/core/ugfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugfm_pkg
// types and constants for the group-filtered moldudp64 parser
// ----------------------------------------------------------------------------
package ugfm_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic [63:0] sequence_number;
        logic [15:0] message_count;
        logic [15:0] message_index;
        logic [15:0] message_length;
        logic        first_of_message;
        logic        last_of_message;
        logic [2:0]  end_status;
        logic        last_item;
    } out_item_t;

    typedef enum logic [7:0] {
        PH_ETH    = 8'b0000_0001,
        PH_IP     = 8'b0000_0010,
        PH_UDP    = 8'b0000_0100,
        PH_MOLD   = 8'b0000_1000,
        PH_MLEN   = 8'b0001_0000,
        PH_MDATA  = 8'b0010_0000,
        PH_DRAIN  = 8'b0100_0000,
        PH_REJECT = 8'b1000_0000
    } phase_t;

    localparam logic [1:0] KIND_SESSION = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_MESSAGE = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PAY_SHORT = 3'd1;
    localparam logic [2:0] ST_MSG_HDR   = 3'd2;
    localparam logic [2:0] ST_MSG_DATA  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_ULEN      = 3'd5;

    localparam logic [0:0] REG_GROUP_ADDRESS = 1'd0;
    localparam logic [0:0] REG_GROUP_PORT    = 1'd1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] MOLD_HDR_BYTES = 16'd20;

endpackage
`default_nettype wire

// File: rtl/core/udp_group_filter_moldudp64_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// output: results of a byte are registered and appear in the cycle after it is accepted
// throughput: one frame byte per cycle while in_stall is low; a byte with two results
// holds its second result in slot 1, stalling input until that result is taken
// reset: asynchronous active low, clears the parser and both filter registers
// ----------------------------------------------------------------------------
// udp_group_filter_moldudp64_parser_core
// ipv4/udp group filter with a streaming moldudp64 parser
// ----------------------------------------------------------------------------
module udp_group_filter_moldudp64_parser_core
    import ugfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] group_address_reg;
    logic [15:0] group_port_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [31:0] cap_reg, cap_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] poff_reg, poff_next;
    logic [63:0] seq_reg, seq_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] clen_reg, clen_next;
    logic [15:0] left_reg, left_next;
    logic [2:0]  err_reg, err_next;

    // output stage: slot 0 shown, slot 1 pending
    logic        o0_vld_reg, o1_vld_reg;
    out_item_t   o0_reg, o1_reg;

    logic        accept;
    out_item_t   r0, r1;
    logic        r0_v, r1_v;

    assign cfg_ready = 1'b1;
    assign out_valid = o0_vld_reg;
    assign out_data  = o0_reg;
    assign in_stall  = o1_vld_reg || (o0_vld_reg && out_stall);
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_address_reg <= '0;
            group_port_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_GROUP_ADDRESS)
                group_address_reg <= cfg_data;
            else
                group_port_reg <= cfg_data[15:0];
        end
    end

    function automatic out_item_t blank();
        out_item_t o;
        o = '0;
        return o;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic        bad;
        logic [15:0] ulen;
        logic [15:0] poff1;
        logic [15:0] cur_idx;
        logic        nm;
        logic [16:0] lim;
        out_item_t   st;
        logic        emit;
        b = in_data.frame_byte;
        bad = 1'b0;
        ulen = '0;
        poff1 = poff_reg + 16'd1;
        cur_idx = idx_reg;
        nm = 1'b0;
        lim = '0;
        st = blank();
        emit = 1'b0;
        phase_next = phase_reg;
        pos_next = pos_reg;
        ihb_next = ihb_reg;
        cap_next = cap_reg;
        plen_next = plen_reg;
        poff_next = poff_reg;
        seq_next = seq_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        clen_next = clen_reg;
        left_next = left_reg;
        err_next = err_reg;
        r0 = blank();
        r1 = blank();
        r0_v = 1'b0;
        r1_v = 1'b0;

        case (phase_reg)
            PH_ETH:
            begin
                if (pos_reg >= 16'd12)
                    cap_next = {cap_reg[23:0], b};
                if (pos_reg >= 16'd13)
                begin
                    phase_next = ({cap_reg[7:0], b} == ETHERTYPE_IPV4) ? PH_IP : PH_REJECT;
                    pos_next = '0;
                    cap_next = '0;
                end
                else
                    pos_next = pos_reg + 16'd1;
            end
            PH_IP:
            begin
                if (pos_reg == 16'd0)
                begin
                    ihb_next = {b[3:0], 2'b00};
                    bad = (b[3:0] < 4'd5);
                end
                else if (pos_reg == 16'd9)
                    bad = (b != PROTO_UDP);
                else if (pos_reg >= 16'd16 && pos_reg <= 16'd19)
                begin
                    cap_next = {cap_reg[23:0], b};
                    if (pos_reg == 16'd19)
                        bad = ({cap_reg[23:0], b} != group_address_reg);
                end
                if (bad)
                    phase_next = PH_REJECT;
                else if ({1'b0, pos_reg} + 17'd1 >= {11'd0, ihb_next})
                begin
                    phase_next = PH_UDP;
                    pos_next = '0;
                    cap_next = '0;
                end
                else
                    pos_next = pos_reg + 16'd1;
            end
            PH_UDP:
            begin
                if (pos_reg == 16'd2 || pos_reg == 16'd4)
                    cap_next = {24'd0, b};
                else if (pos_reg == 16'd3 || pos_reg == 16'd5)
                    cap_next = {16'd0, cap_reg[7:0], b};
                if (pos_reg == 16'd3 && cap_next[15:0] != group_port_reg)
                    phase_next = PH_REJECT;
                else if (pos_reg >= 16'd7)
                begin
                    ulen = cap_next[15:0];
                    pos_next = '0;
                    cap_next = '0;
                    poff_next = '0;
                    if (ulen < 16'd8)
                    begin
                        plen_next = '0;
                        err_next = ST_ULEN;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        plen_next = ulen - 16'd8;
                        if (plen_next < MOLD_HDR_BYTES)
                        begin
                            err_next = ST_PAY_SHORT;
                            phase_next = PH_DRAIN;
                        end
                        else
                            phase_next = PH_MOLD;
                    end
                end
                else
                    pos_next = pos_reg + 16'd1;
            end
            PH_MOLD:
            begin
                poff_next = poff1;
                if (pos_reg < 16'd10)
                begin
                    r0_v = 1'b1;
                    r0.item_kind = KIND_SESSION;
                    r0.data_byte = b;
                end
                else if (pos_reg < 16'd18)
                    seq_next = {seq_reg[55:0], b};
                else
                    cnt_next = {cnt_reg[7:0], b};
                if (pos_reg >= 16'd19)
                begin
                    r0_v = 1'b1;
                    r0.item_kind = KIND_SUMMARY;
                    r0.sequence_number = seq_next;
                    r0.message_count = cnt_next;
                    idx_next = '0;
                    cur_idx = '0;
                    nm = 1'b1;
                end
                else
                    pos_next = pos_reg + 16'd1;
            end
            PH_MLEN:
            begin
                poff_next = poff1;
                cap_next = {16'd0, cap_reg[7:0], b};
                if (pos_reg == 16'd0)
                    pos_next = 16'd1;
                else
                begin
                    clen_next = cap_next[15:0];
                    cap_next = '0;
                    pos_next = '0;
                    lim = {1'b0, poff1} + {1'b0, clen_next};
                    if (lim > {1'b0, plen_reg})
                    begin
                        err_next = ST_MSG_DATA;
                        phase_next = PH_DRAIN;
                    end
                    else if (clen_next == 16'd0)
                    begin
                        cur_idx = idx_reg + 16'd1;
                        idx_next = cur_idx;
                        nm = 1'b1;
                    end
                    else
                    begin
                        left_next = clen_next;
                        phase_next = PH_MDATA;
                    end
                end
            end
            PH_MDATA:
            begin
                poff_next = poff1;
                r0_v = 1'b1;
                r0.item_kind = KIND_MESSAGE;
                r0.data_byte = b;
                r0.message_index = idx_reg;
                r0.message_length = clen_reg;
                r0.first_of_message = (left_reg == clen_reg);
                r0.last_of_message = (left_reg == 16'd1);
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    cur_idx = idx_reg + 16'd1;
                    idx_next = cur_idx;
                    nm = 1'b1;
                end
            end
            PH_DRAIN:
            begin
                if (poff_reg < plen_reg)
                    poff_next = poff1;
            end
            default:
            begin
            end
        endcase

        if (nm)
        begin
            pos_next = '0;
            cap_next = '0;
            if (cur_idx >= cnt_next)
            begin
                err_next = ST_OK;
                phase_next = PH_DRAIN;
            end
            else if ({1'b0, poff_next} + 17'd2 > {1'b0, plen_next})
            begin
                err_next = ST_MSG_HDR;
                phase_next = PH_DRAIN;
            end
            else
                phase_next = PH_MLEN;
        end

        if (in_data.frame_end)
        begin
            st.item_kind = KIND_STATUS;
            if (phase_next == PH_UDP && pos_next >= 16'd4)
            begin
                emit = 1'b1;
                st.end_status = ST_TRUNC;
            end
            else if (phase_next == PH_MOLD || phase_next == PH_MLEN ||
                     phase_next == PH_MDATA || phase_next == PH_DRAIN)
            begin
                emit = 1'b1;
                if (err_next != ST_OK)
                    st.end_status = err_next;
                else if (poff_next < plen_next)
                    st.end_status = ST_TRUNC;
            end
            phase_next = PH_ETH;
            pos_next = '0;
            ihb_next = '0;
            cap_next = '0;
            plen_next = '0;
            poff_next = '0;
            seq_next = '0;
            cnt_next = '0;
            idx_next = '0;
            clen_next = '0;
            left_next = '0;
            err_next = '0;
        end

        if (emit)
        begin
            if (r0_v)
            begin
                r1 = st;
                r1.last_item = 1'b1;
                r1_v = 1'b1;
            end
            else
            begin
                r0 = st;
                r0.last_item = 1'b1;
                r0_v = 1'b1;
            end
        end
        else if (r0_v)
            r0.last_item = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ETH;
            pos_reg   <= '0;
            ihb_reg   <= '0;
            cap_reg   <= '0;
            plen_reg  <= '0;
            poff_reg  <= '0;
            seq_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            clen_reg  <= '0;
            left_reg  <= '0;
            err_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ihb_reg   <= ihb_next;
            cap_reg   <= cap_next;
            plen_reg  <= plen_next;
            poff_reg  <= poff_next;
            seq_reg   <= seq_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            clen_reg  <= clen_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o0_vld_reg <= 1'b0;
            o1_vld_reg <= 1'b0;
        end
        else if (o0_vld_reg && !out_stall)
        begin
            if (o1_vld_reg)
            begin
                o1_vld_reg <= 1'b0;
            end
            else
            begin
                o0_vld_reg <= accept && r0_v;
                o1_vld_reg <= accept && r1_v;
            end
        end
        else if (!o0_vld_reg)
        begin
            o0_vld_reg <= accept && r0_v;
            o1_vld_reg <= accept && r1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o0_vld_reg && !out_stall && o1_vld_reg)
            o0_reg <= o1_reg;
        else if (accept)
        begin
            o0_reg <= r0;
            o1_reg <= r1;
        end
    end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// frame-level checks of the group-filtered moldudp64 parser: directed frames
// for each filter and error case, then random frames, with a local parser
// model predicting every transaction and random idling on both channels
// ----------------------------------------------------------------------------
module tb;
    import ugfm_pkg::*;

    localparam int LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    udp_group_filter_moldudp64_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser model state
    logic [31:0] m_addr;
    logic [15:0] m_port;
    phase_t      m_phase;
    logic [15:0] m_pos;
    logic [7:0]  m_ihl;
    logic [31:0] m_field;
    logic [15:0] m_plen;
    logic [15:0] m_poff;
    logic [63:0] m_seq;
    logic [15:0] m_count;
    logic [15:0] m_idx;
    logic [15:0] m_len;
    logic [15:0] m_left;
    logic [2:0]  m_err;

    out_item_t pending_items[$];
    int        errors;
    int        idle_cycles;
    bit        calm;
    logic [7:0] frame[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what, input out_item_t got, input out_item_t exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    function automatic out_item_t blank();
        out_item_t r;
        r = '0;
        return r;
    endfunction

    task automatic clear_frame_state();
        m_phase = PH_ETH;
        m_pos = 0;
        m_ihl = 0;
        m_field = 0;
        m_plen = 0;
        m_poff = 0;
        m_seq = 0;
        m_count = 0;
        m_idx = 0;
        m_len = 0;
        m_left = 0;
        m_err = ST_OK;
    endtask

    task automatic drain(input logic [2:0] code);
        m_err = code;
        m_phase = PH_DRAIN;
    endtask

    task automatic after_message();
        m_pos = 0;
        m_field = 0;
        if (m_idx >= m_count)
            drain(ST_OK);
        else if ({16'd0, m_poff} + 32'd2 > {16'd0, m_plen})
            drain(ST_MSG_HDR);
        else
            m_phase = PH_MLEN;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        out_item_t res[$];
        out_item_t r;
        logic [15:0] pos;
        logic [31:0] ulen;
        bit bad;
        bit emit;
        logic [2:0] st;
        pos = m_pos;
        bad = 0;
        emit = 0;
        st = ST_OK;
        case (m_phase)
            PH_ETH:
            begin
                if (pos >= 12)
                    m_field = {m_field[23:0], b};
                if (pos >= 13)
                begin
                    m_phase = (m_field[15:0] == ETHERTYPE_IPV4) ? PH_IP : PH_REJECT;
                    m_pos = 0;
                    m_field = 0;
                end
                else
                    m_pos = pos + 1;
            end
            PH_IP:
            begin
                if (pos == 0)
                begin
                    m_ihl = {2'b0, b[3:0], 2'b0};
                    bad = m_ihl < 20;
                end
                else if (pos == 9)
                    bad = b != PROTO_UDP;
                else if (pos >= 16 && pos <= 19)
                begin
                    m_field = {m_field[23:0], b};
                    if (pos == 19)
                        bad = m_field != m_addr;
                end
                if (bad)
                    m_phase = PH_REJECT;
                else if (32'(pos) + 1 >= 32'(m_ihl))
                begin
                    m_phase = PH_UDP;
                    m_pos = 0;
                    m_field = 0;
                end
                else
                    m_pos = pos + 1;
            end
            PH_UDP:
            begin
                if (pos == 2 || pos == 4)
                    m_field = {24'd0, b};
                else if (pos == 3 || pos == 5)
                begin
                    m_field = {16'd0, m_field[7:0], b};
                    if (pos == 3 && m_field[15:0] != m_port)
                    begin
                        m_phase = PH_REJECT;
                        bad = 1;
                    end
                end
                if (!bad)
                begin
                    if (pos >= 7)
                    begin
                        ulen = {16'd0, m_field[15:0]};
                        m_pos = 0;
                        m_field = 0;
                        m_poff = 0;
                        if (ulen < 8)
                        begin
                            m_plen = 0;
                            drain(ST_ULEN);
                        end
                        else
                        begin
                            m_plen = ulen[15:0] - 16'd8;
                            if (m_plen < MOLD_HDR_BYTES)
                                drain(ST_PAY_SHORT);
                            else
                                m_phase = PH_MOLD;
                        end
                    end
                    else
                        m_pos = pos + 1;
                end
            end
            PH_MOLD:
            begin
                m_poff++;
                if (pos < 10)
                begin
                    r = blank();
                    r.item_kind = KIND_SESSION;
                    r.data_byte = b;
                    res.push_back(r);
                end
                else if (pos < 18)
                    m_seq = {m_seq[55:0], b};
                else
                    m_count = {m_count[7:0], b};
                if (pos >= 19)
                begin
                    r = blank();
                    r.item_kind = KIND_SUMMARY;
                    r.sequence_number = m_seq;
                    r.message_count = m_count;
                    res.push_back(r);
                    m_idx = 0;
                    after_message();
                end
                else
                    m_pos = pos + 1;
            end
            PH_MLEN:
            begin
                m_poff++;
                m_field = {16'd0, m_field[7:0], b};
                if (pos == 0)
                    m_pos = 1;
                else
                begin
                    m_len = m_field[15:0];
                    m_field = 0;
                    m_pos = 0;
                    if (32'(m_poff) + 32'(m_len) > 32'(m_plen))
                        drain(ST_MSG_DATA);
                    else if (m_len == 0)
                    begin
                        m_idx++;
                        after_message();
                    end
                    else
                    begin
                        m_left = m_len;
                        m_phase = PH_MDATA;
                    end
                end
            end
            PH_MDATA:
            begin
                m_poff++;
                r = blank();
                r.item_kind = KIND_MESSAGE;
                r.data_byte = b;
                r.message_index = m_idx;
                r.message_length = m_len;
                r.first_of_message = m_left == m_len;
                r.last_of_message = m_left == 1;
                res.push_back(r);
                m_left--;
                if (m_left == 0)
                begin
                    m_idx++;
                    after_message();
                end
            end
            PH_DRAIN:
            begin
                if (m_poff < m_plen)
                    m_poff++;
            end
            default:
            begin
            end
        endcase
        if (fin)
        begin
            if (m_phase == PH_UDP && m_pos >= 4)
            begin
                emit = 1;
                st = ST_TRUNC;
            end
            else if (m_phase inside {PH_MOLD, PH_MLEN, PH_MDATA, PH_DRAIN})
            begin
                emit = 1;
                if (m_err != ST_OK)
                    st = m_err;
                else if (m_poff < m_plen)
                    st = ST_TRUNC;
            end
            if (emit)
            begin
                r = blank();
                r.item_kind = KIND_STATUS;
                r.end_status = st;
                res.push_back(r);
            end
            clear_frame_state();
        end
        if (res.size() > 0)
            res[res.size() - 1].last_item = 1'b1;
        foreach (res[i])
            pending_items.push_back(res[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{frame_byte: b, frame_end: fin};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, fin);
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_GROUP_ADDRESS)
            m_addr = val;
        else
            m_port = val[15:0];
    endtask

    // builds headers; ulen is the udp length field, ihl in 32-bit words
    task automatic build_headers(input logic [15:0] etype, input logic [3:0] ihl,
                                 input logic [7:0] proto, input logic [31:0] dst,
                                 input logic [15:0] dport, input logic [15:0] ulen);
        for (int i = 0; i < 12; i++)
            frame.push_back(8'($urandom));
        frame.push_back(etype[15:8]);
        frame.push_back(etype[7:0]);
        frame.push_back({4'h4, ihl});
        for (int i = 1; i < 9; i++)
            frame.push_back(8'($urandom));
        frame.push_back(proto);
        for (int i = 10; i < 16; i++)
            frame.push_back(8'($urandom));
        for (int i = 0; i < 4; i++)
            frame.push_back(dst[31 - 8 * i -: 8]);
        for (int i = 20; i < 4 * ihl; i++)
            frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(dport[15:8]);
        frame.push_back(dport[7:0]);
        frame.push_back(ulen[15:8]);
        frame.push_back(ulen[7:0]);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
    endtask

    // a moldudp64 frame with nmsg messages of up to maxlen bytes; trim shortens the udp length and extra adds bytes
    task automatic build_mold(input int nmsg, input int maxlen, input int ihl,
                              input int trim, input int extra);
        logic [7:0] pay[$];
        int l;
        for (int i = 0; i < 18; i++)
            pay.push_back(8'($urandom));
        pay.push_back(8'(nmsg >> 8));
        pay.push_back(8'(nmsg));
        for (int k = 0; k < nmsg; k++)
        begin
            l = $urandom_range(maxlen);
            pay.push_back(8'(l >> 8));
            pay.push_back(8'(l));
            for (int j = 0; j < l; j++)
                pay.push_back(8'($urandom));
        end
        for (int i = 0; i < extra; i++)
            pay.push_back(8'($urandom));
        build_headers(ETHERTYPE_IPV4, 4'(ihl), PROTO_UDP, m_addr, m_port,
                      16'(pay.size() + 8 - trim));
        foreach (pay[i])
            frame.push_back(pay[i]);
    endtask

    task automatic test_filters();
        build_headers(16'h8100, 4'd5, PROTO_UDP, m_addr, m_port, 16'd40);
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd4, PROTO_UDP, m_addr, m_port, 16'd40);
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, 8'd6, m_addr, m_port, 16'd40);
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, ~m_addr, m_port, 16'd40);
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, ~m_port, 16'd40);
        send_frame();
    endtask

    task automatic test_header_errors();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, m_port, 16'd40);
        repeat (3) void'(frame.pop_back());
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, m_port, 16'd7);
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, m_port, 16'd27);
        repeat (19) frame.push_back(8'($urandom));
        send_frame();
        build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, m_port, 16'hFFFF);
        repeat (20) frame.push_back(8'hFF);
        send_frame();
    endtask

    task automatic test_messages();
        build_mold(0, 0, 5, 0, 3);
        send_frame();
        build_mold(3, 0, 15, 0, 0);
        send_frame();
        build_mold(3, 6, 5, 1, 0);
        send_frame();
        build_mold(2, 6, 6, 0, 1);
        frame.push_back(8'h00);
        send_frame();
        build_mold(2, 5, 5, -4, 0);
        send_frame();
        build_mold(4, 4, 5, 0, 0);
        repeat (5) void'(frame.pop_back());
        send_frame();
    endtask

    task automatic test_random_frames();
        int sent;
        int pick;
        sent = 0;
        while (sent < 150)
        begin
            calm = sent < 80;
            pick = $urandom_range(99);
            if (pick < 75)
                build_mold($urandom_range(4), $urandom_range(8), $urandom_range(5, 7),
                           ($urandom_range(9) == 0) ? $urandom_range(3) : 0,
                           $urandom_range(3) == 0 ? $urandom_range(3) : 0);
            else if (pick < 85)
                build_headers(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, m_addr, m_port,
                              16'($urandom_range(40)));
            else
                for (int i = $urandom_range(1, 60); i > 0; i--)
                    frame.push_back(8'($urandom));
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 8)) void'(frame.pop_back());
            if (frame.size() == 0)
                frame.push_back(8'($urandom));
            if ($urandom_range(9) == 0)
                frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
            sent += frame.size();
            send_frame();
        end
        calm = 0;
    endtask

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_items.size() == 0)
                    report("unexpected", out_data, '0);
                else
                begin
                    exp = pending_items.pop_front();
                    if (out_data.item_kind != exp.item_kind)
                        report("item_kind", out_data, exp);
                    if (out_data.data_byte != exp.data_byte)
                        report("data_byte", out_data, exp);
                    if (out_data.sequence_number != exp.sequence_number)
                        report("sequence_number", out_data, exp);
                    if (out_data.message_count != exp.message_count)
                        report("message_count", out_data, exp);
                    if (out_data.message_index != exp.message_index)
                        report("message_index", out_data, exp);
                    if (out_data.message_length != exp.message_length)
                        report("message_length", out_data, exp);
                    if (out_data.first_of_message != exp.first_of_message)
                        report("first_of_message", out_data, exp);
                    if (out_data.last_of_message != exp.last_of_message)
                        report("last_of_message", out_data, exp);
                    if (out_data.end_status != exp.end_status)
                        report("end_status", out_data, exp);
                    if (out_data.last_item != exp.last_item)
                        report("last_item", out_data, exp);
                end
            end
            out_stall <= !calm && $urandom_range(99) < 20;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT)
            begin
                $display("[udp_group_filter_moldudp64_parser_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        calm = 0;
        m_addr = 0;
        m_port = 0;
        clear_frame_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GROUP_ADDRESS;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_messages();
        write_reg(REG_GROUP_ADDRESS, 32'hEF01_0203);
        write_reg(REG_GROUP_PORT, 32'd26400);
        test_filters();
        test_header_errors();
        write_reg(REG_GROUP_ADDRESS, $urandom);
        write_reg(REG_GROUP_PORT, $urandom);
        test_random_frames();
        wait_idle();
        if (errors == 0)
            $display("[udp_group_filter_moldudp64_parser_core] OK");
        else
            $display("[udp_group_filter_moldudp64_parser_core] ERROR");
        $finish;
    end
endmodule
